// ===== hdl/mrrt_pkg.sv =====
// Shared types and constants of the memory region range table.
// Used by mrrt_ctrl, mrrt_dpath, memory_region_range_table and the testbench; no dependencies.
package mrrt_pkg;

	localparam int ADDR_W      = 64;
	localparam int DEV_W       = 32;
	localparam int TAG_W       = 32;
	localparam int MASK_W      = 4;
	localparam int PROT_W      = 2;
	localparam int CMD_W       = 3;
	localparam int TDATA_W     = 264;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_VALIDATE     = 3'd0,
		CMD_ADD          = 3'd1,
		CMD_REMOVE       = 3'd2,
		CMD_FIND_HANDLE  = 3'd3,
		CMD_FIND_START   = 3'd4,
		CMD_FIND_CONTAIN = 3'd5,
		CMD_LIST         = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH,
		S_RDTAG,
		S_EMIT,
		S_OUT
	} fsm_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load;
		logic clear;
		logic scan;
		logic take;
		logic load_plain;
		logic load_entry;
		logic last;
	} ctl_t;

	// datapath -> controller status
	typedef struct packed {
		logic [CMD_W-1:0] op;
		logic             invalid;
		logic             found;
	} sts_t;

endpackage

// ===== hdl/mrrt_ctrl.sv =====
// Command sequencer of the memory region range table: scan index, result count, handshakes.
// Depends on mrrt_pkg.
module mrrt_ctrl #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	output logic                              out_valid,
	input  logic                              out_ready,
	input  mrrt_pkg::sts_t                    sts,
	output mrrt_pkg::ctl_t                    ctl,
	output logic [$clog2(TABLE_ENTRIES)-1:0]  idx
);

	localparam int IW = $clog2(TABLE_ENTRIES);

	mrrt_pkg::fsm_t               state_q, state_d;
	logic [IW-1:0]                idx_q;
	logic [mrrt_pkg::CNT_W-1:0]   cnt_q;
	logic                         have_pend_q;
	logic                         last_q;
	logic                         scan_end;
	logic                         is_list;
	logic                         more;

	assign idx      = idx_q;
	assign scan_end = (idx_q == IW'(TABLE_ENTRIES - 1));
	assign is_list  = (sts.op == mrrt_pkg::CMD_LIST);
	assign more     = is_list && !last_q && have_pend_q && !sts.invalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrrt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			mrrt_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load  = 1'b1;
					ctl.clear = 1'b1;
					state_d   = mrrt_pkg::S_SCAN;
				end
			end
			mrrt_pkg::S_SCAN: begin
				ctl.scan = 1'b1;
				if (scan_end) begin
					state_d = mrrt_pkg::S_FINISH;
				end
			end
			mrrt_pkg::S_FINISH: begin
				if (sts.invalid || sts.op == mrrt_pkg::CMD_VALIDATE ||
				    sts.op == mrrt_pkg::CMD_ADD || sts.op == mrrt_pkg::CMD_REMOVE) begin
					ctl.load_plain = 1'b1;
					state_d        = mrrt_pkg::S_OUT;
				end else if (is_list && have_pend_q) begin
					state_d = mrrt_pkg::S_RDTAG;
				end else if (!sts.found) begin
					ctl.load_plain = 1'b1;
					state_d        = mrrt_pkg::S_OUT;
				end else if (is_list) begin
					// first pick of the list: hold it and look ahead for the next
					ctl.take  = 1'b1;
					ctl.clear = 1'b1;
					state_d   = mrrt_pkg::S_SCAN;
				end else begin
					ctl.take = 1'b1;
					state_d  = mrrt_pkg::S_RDTAG;
				end
			end
			mrrt_pkg::S_RDTAG: begin
				state_d = mrrt_pkg::S_EMIT;
			end
			mrrt_pkg::S_EMIT: begin
				ctl.load_entry = 1'b1;
				ctl.last       = last_q;
				state_d        = mrrt_pkg::S_OUT;
			end
			mrrt_pkg::S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (more) begin
						ctl.take  = 1'b1;
						ctl.clear = 1'b1;
						state_d   = mrrt_pkg::S_SCAN;
					end else begin
						state_d = mrrt_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_d = mrrt_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			cnt_q       <= '0;
			have_pend_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (ctl.clear) begin
				idx_q <= '0;
			end else if (ctl.scan) begin
				idx_q <= idx_q + IW'(1);
			end
			if (ctl.load) begin
				cnt_q       <= '0;
				have_pend_q <= 1'b0;
			end else begin
				if (ctl.take) begin
					have_pend_q <= 1'b1;
				end
				if (state_q == mrrt_pkg::S_OUT && out_ready && more) begin
					cnt_q <= cnt_q + mrrt_pkg::CNT_W'(1);
				end
			end
			if (state_q == mrrt_pkg::S_FINISH) begin
				last_q <= !is_list || !sts.found ||
				          (cnt_q == mrrt_pkg::CNT_W'(mrrt_pkg::MAX_RESULTS - 1));
			end
		end
	end

endmodule

// ===== hdl/mrrt_dpath.sv =====
// Datapath of the memory region range table: entry storage, tag memory, scan compare
// and result registers. Depends on mrrt_pkg; driven by mrrt_ctrl.
module mrrt_dpath #(
	parameter int TABLE_ENTRIES  = 16,
	parameter int PROTOCOL_COUNT = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  mrrt_pkg::ctl_t                        ctl,
	input  logic [$clog2(TABLE_ENTRIES)-1:0]      idx,
	output mrrt_pkg::sts_t                        sts,
	input  logic [mrrt_pkg::CMD_W-1:0]            in_cmd,
	input  logic [mrrt_pkg::PROT_W-1:0]           in_protocol,
	input  logic signed [mrrt_pkg::DEV_W-1:0]     in_device,
	input  logic [mrrt_pkg::ADDR_W-1:0]           in_addr,
	input  logic [mrrt_pkg::ADDR_W-1:0]           in_length,
	input  logic [mrrt_pkg::ADDR_W-1:0]           in_handle,
	input  logic [mrrt_pkg::TAG_W-1:0]            in_tag,
	output logic [1:0]                            status,
	output logic                                  has_region,
	output logic [mrrt_pkg::ADDR_W-1:0]           region_addr,
	output logic [mrrt_pkg::ADDR_W-1:0]           region_length,
	output logic signed [mrrt_pkg::DEV_W-1:0]     region_device,
	output logic [mrrt_pkg::ADDR_W-1:0]           region_handle,
	output logic [mrrt_pkg::MASK_W-1:0]           protocol_mask,
	output logic [mrrt_pkg::TAG_W-1:0]            region_tag,
	output logic                                  last
);

	localparam int IW    = $clog2(TABLE_ENTRIES);
	localparam int DEPTH = TABLE_ENTRIES * PROTOCOL_COUNT;
	localparam int TW    = $clog2(DEPTH);
	localparam int AW    = mrrt_pkg::ADDR_W;

	// latched command
	logic [mrrt_pkg::CMD_W-1:0]        cmd_q;
	logic [mrrt_pkg::PROT_W-1:0]       prot_q;
	logic signed [mrrt_pkg::DEV_W-1:0] dev_q;
	logic [AW-1:0]                     a_q, len_q, h_q;
	logic [mrrt_pkg::TAG_W-1:0]        tag_q;
	logic [AW:0]                       aend_q;
	logic                              bad_q;

	// table
	logic                              valid_q [TABLE_ENTRIES];
	logic [AW-1:0]                     ent_start_q [TABLE_ENTRIES];
	logic [AW-1:0]                     ent_length_q [TABLE_ENTRIES];
	logic signed [mrrt_pkg::DEV_W-1:0] ent_device_q [TABLE_ENTRIES];
	logic [AW-1:0]                     ent_handle_q [TABLE_ENTRIES];
	logic [PROTOCOL_COUNT-1:0]         ent_prot_q [TABLE_ENTRIES];
	logic [mrrt_pkg::TAG_W-1:0]        tag_mem_q [DEPTH];
	logic [mrrt_pkg::TAG_W-1:0]        rd_tag_q;
	logic                              taken_q [TABLE_ENTRIES];

	// scan accumulators
	logic          found_v_q, dup_q, free_v_q, eq_hit_q, eq_ok_q, abv_v_q, blw_v_q;
	logic [IW-1:0] found_idx_q, free_idx_q, pend_idx_q;
	logic [AW-1:0] found_key_q, abv_s_q, blw_s_q, blw_l_q;

	// current entry under scan
	logic                              e_v, e_hp, e_devm, e_sa;
	logic [AW-1:0]                     e_s, e_l, e_h;
	logic [PROTOCOL_COUNT-1:0]         e_pm, pbit, rem_pm;
	logic                              invalid;
	logic [1:0]                        vstat, astat, pstat;
	logic                              commit, add_new;
	logic [IW-1:0]                     widx;
	logic [7:0]                        pend_pm8;

	function automatic logic [TW-1:0] taddr(input logic [IW-1:0] e,
	                                        input logic [mrrt_pkg::PROT_W-1:0] p);
		taddr = TW'(32'(e) * PROTOCOL_COUNT + 32'(p));
	endfunction

	assign pbit    = PROTOCOL_COUNT'(1) << prot_q;
	assign e_v     = valid_q[idx];
	assign e_s     = ent_start_q[idx];
	assign e_l     = ent_length_q[idx];
	assign e_h     = ent_handle_q[idx];
	assign e_pm    = ent_prot_q[idx];
	assign e_hp    = e_v && |(e_pm & pbit);
	assign e_devm  = e_v && (ent_device_q[idx] == dev_q);
	assign e_sa    = (e_s == a_q);

	assign invalid = (cmd_q > mrrt_pkg::CMD_LIST) ||
	                 (cmd_q != mrrt_pkg::CMD_VALIDATE && 32'(prot_q) >= PROTOCOL_COUNT);

	assign sts.op      = cmd_q;
	assign sts.invalid = invalid;
	assign sts.found   = found_v_q;

	always_comb begin
		if (bad_q) begin
			vstat = mrrt_pkg::ST_INVALID;
		end else if (eq_hit_q) begin
			vstat = eq_ok_q ? mrrt_pkg::ST_OK : mrrt_pkg::ST_INVALID;
		end else if (abv_v_q && ({1'b0, abv_s_q} < aend_q)) begin
			vstat = mrrt_pkg::ST_INVALID;
		end else if (blw_v_q && (({1'b0, blw_s_q} + {1'b0, blw_l_q}) > {1'b0, a_q})) begin
			vstat = mrrt_pkg::ST_INVALID;
		end else begin
			vstat = mrrt_pkg::ST_OK;
		end
	end

	always_comb begin
		if (found_v_q) begin
			astat = mrrt_pkg::ST_OK;
		end else if (dup_q) begin
			astat = mrrt_pkg::ST_INVALID;
		end else if (!free_v_q) begin
			astat = mrrt_pkg::ST_FULL;
		end else begin
			astat = mrrt_pkg::ST_OK;
		end
	end

	always_comb begin
		if (invalid) begin
			pstat = mrrt_pkg::ST_INVALID;
		end else begin
			case (cmd_q)
				mrrt_pkg::CMD_VALIDATE:     pstat = vstat;
				mrrt_pkg::CMD_ADD:          pstat = astat;
				mrrt_pkg::CMD_REMOVE:       pstat = found_v_q ? mrrt_pkg::ST_OK
				                                              : mrrt_pkg::ST_INVALID;
				mrrt_pkg::CMD_FIND_HANDLE,
				mrrt_pkg::CMD_FIND_START,
				mrrt_pkg::CMD_FIND_CONTAIN: pstat = mrrt_pkg::ST_NOT_FOUND;
				mrrt_pkg::CMD_LIST:         pstat = mrrt_pkg::ST_OK;
				default:                    pstat = mrrt_pkg::ST_INVALID;
			endcase
		end
	end

	assign commit  = ctl.load_plain && !invalid;
	assign add_new = !found_v_q && !dup_q && free_v_q;
	assign widx    = found_v_q ? found_idx_q : free_idx_q;
	assign rem_pm  = ent_prot_q[found_idx_q] & ~pbit;

	// latch the command; the end address and range check are settled here
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= in_cmd;
			prot_q <= in_protocol;
			dev_q  <= in_device;
			a_q    <= in_addr;
			len_q  <= in_length;
			h_q    <= in_handle;
			tag_q  <= in_tag;
			aend_q <= {1'b0, in_addr} + {1'b0, in_length};
			bad_q  <= (in_addr == '0) || (in_length == '0) ||
			          (in_length > ~in_addr);
		end
	end

	// scan accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_v_q   <= 1'b0;
			dup_q       <= 1'b0;
			free_v_q    <= 1'b0;
			eq_hit_q    <= 1'b0;
			abv_v_q     <= 1'b0;
			blw_v_q     <= 1'b0;
		end else if (ctl.clear) begin
			found_v_q   <= 1'b0;
			dup_q       <= 1'b0;
			free_v_q    <= 1'b0;
			eq_hit_q    <= 1'b0;
			abv_v_q     <= 1'b0;
			blw_v_q     <= 1'b0;
		end else if (ctl.scan) begin
			case (cmd_q)
				mrrt_pkg::CMD_VALIDATE: begin
					if (e_devm) begin
						if (e_sa) begin
							eq_hit_q <= 1'b1;
						end else if (e_s > a_q) begin
							if (!abv_v_q || e_s < abv_s_q) begin
								abv_v_q <= 1'b1;
							end
						end else if (!blw_v_q || e_s > blw_s_q) begin
							blw_v_q <= 1'b1;
						end
					end
				end
				mrrt_pkg::CMD_ADD: begin
					if (e_devm && e_sa && !found_v_q) begin
						found_v_q <= 1'b1;
					end
					if (e_v && e_h == h_q) begin
						dup_q <= 1'b1;
					end
					if (!e_v) begin
						free_v_q <= 1'b1;
					end
				end
				mrrt_pkg::CMD_REMOVE: begin
					if (e_v && e_h == h_q) begin
						found_v_q <= 1'b1;
					end
				end
				mrrt_pkg::CMD_FIND_HANDLE: begin
					if (e_hp && e_h == h_q) begin
						found_v_q <= 1'b1;
					end
				end
				mrrt_pkg::CMD_FIND_START: begin
					if (e_hp && e_devm && e_sa) begin
						found_v_q <= 1'b1;
					end
				end
				mrrt_pkg::CMD_FIND_CONTAIN: begin
					if (e_hp && e_devm && e_s <= a_q &&
					    (aend_q - {1'b0, e_s}) <= {1'b0, e_l} &&
					    (!found_v_q || e_s > found_key_q)) begin
						found_v_q <= 1'b1;
					end
				end
				mrrt_pkg::CMD_LIST: begin
					if (e_hp && !taken_q[idx] && (!found_v_q || e_h < found_key_q)) begin
						found_v_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// accumulator payload: index and key of the best candidate so far
	always_ff @(posedge clk) begin
		if (ctl.scan) begin
			case (cmd_q)
				mrrt_pkg::CMD_VALIDATE: begin
					if (e_devm) begin
						if (e_sa) begin
							if (!eq_hit_q) begin
								eq_ok_q <= (e_l == len_q);
							end
						end else if (e_s > a_q) begin
							if (!abv_v_q || e_s < abv_s_q) begin
								abv_s_q <= e_s;
							end
						end else if (!blw_v_q || e_s > blw_s_q) begin
							blw_s_q <= e_s;
							blw_l_q <= e_l;
						end
					end
				end
				mrrt_pkg::CMD_ADD: begin
					if (e_devm && e_sa && !found_v_q) begin
						found_idx_q <= idx;
					end
					if (!e_v && !free_v_q) begin
						free_idx_q <= idx;
					end
				end
				mrrt_pkg::CMD_REMOVE,
				mrrt_pkg::CMD_FIND_HANDLE: begin
					if ((cmd_q == mrrt_pkg::CMD_REMOVE ? e_v : e_hp) && e_h == h_q) begin
						found_idx_q <= idx;
					end
				end
				mrrt_pkg::CMD_FIND_START: begin
					if (e_hp && e_devm && e_sa) begin
						found_idx_q <= idx;
					end
				end
				mrrt_pkg::CMD_FIND_CONTAIN: begin
					if (e_hp && e_devm && e_s <= a_q &&
					    (aend_q - {1'b0, e_s}) <= {1'b0, e_l} &&
					    (!found_v_q || e_s > found_key_q)) begin
						found_idx_q <= idx;
						found_key_q <= e_s;
					end
				end
				mrrt_pkg::CMD_LIST: begin
					if (e_hp && !taken_q[idx] && (!found_v_q || e_h < found_key_q)) begin
						found_idx_q <= idx;
						found_key_q <= e_h;
					end
				end
				default: begin
				end
			endcase
		end
		if (ctl.take) begin
			pend_idx_q <= found_idx_q;
		end
	end

	// valid and taken bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				taken_q[i] <= 1'b0;
			end
		end else begin
			if (ctl.load) begin
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					taken_q[i] <= 1'b0;
				end
			end else if (ctl.take) begin
				taken_q[found_idx_q] <= 1'b1;
			end
			if (commit && cmd_q == mrrt_pkg::CMD_ADD && add_new) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (commit && cmd_q == mrrt_pkg::CMD_REMOVE && found_v_q && rem_pm == '0) begin
				valid_q[found_idx_q] <= 1'b0;
			end
		end
	end

	// entry fields
	always_ff @(posedge clk) begin
		if (commit && cmd_q == mrrt_pkg::CMD_ADD) begin
			if (found_v_q) begin
				ent_prot_q[found_idx_q] <= ent_prot_q[found_idx_q] | pbit;
			end else if (add_new) begin
				ent_start_q[free_idx_q]  <= a_q;
				ent_length_q[free_idx_q] <= len_q;
				ent_device_q[free_idx_q] <= dev_q;
				ent_handle_q[free_idx_q] <= h_q;
				ent_prot_q[free_idx_q]   <= pbit;
			end
		end
		if (commit && cmd_q == mrrt_pkg::CMD_REMOVE && found_v_q) begin
			ent_prot_q[found_idx_q] <= rem_pm;
		end
	end

	// tag memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (commit && cmd_q == mrrt_pkg::CMD_ADD && (found_v_q || add_new)) begin
			tag_mem_q[taddr(widx, prot_q)] <= tag_q;
		end
		rd_tag_q <= tag_mem_q[taddr(pend_idx_q, prot_q)];
	end

	assign pend_pm8 = 8'(ent_prot_q[pend_idx_q]);

	// result register
	always_ff @(posedge clk) begin
		if (ctl.load_plain) begin
			status        <= pstat;
			has_region    <= 1'b0;
			region_addr   <= '0;
			region_length <= '0;
			region_device <= '0;
			region_handle <= '0;
			protocol_mask <= '0;
			region_tag    <= '0;
			last          <= 1'b1;
		end else if (ctl.load_entry) begin
			status        <= mrrt_pkg::ST_OK;
			has_region    <= 1'b1;
			region_addr   <= ent_start_q[pend_idx_q];
			region_length <= ent_length_q[pend_idx_q];
			region_device <= ent_device_q[pend_idx_q];
			region_handle <= ent_handle_q[pend_idx_q];
			protocol_mask <= pend_pm8[mrrt_pkg::MASK_W-1:0];
			region_tag    <= rd_tag_q;
			last          <= ctl.last;
		end
	end

endmodule

// ===== hdl/memory_region_range_table.sv =====
// Memory region range table: top level joining the command sequencer and the datapath.
// Sequence: every command scans all entries; a result with an entry then fetches its tag,
// and the first list result waits for the pick plus a look-ahead scan for the next one,
// while each later list result follows one more look-ahead scan after the previous transfer.
// Throughput: one command at a time; s_tready returns the cycle after the last result's transfer.
// Reset: arst_n clears the valid bits and the sequencer at once; no clearing pass is needed.
module memory_region_range_table #(
	parameter int TABLE_ENTRIES  = 16,
	parameter int PROTOCOL_COUNT = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// protocol[1:0], device[33:2], addr[97:34], length[161:98], handle[225:162],
	// native_tag[257:226], zero pad
	input  logic [mrrt_pkg::TDATA_W-1:0]  s_tdata,
	// cmd[2:0]
	input  logic [mrrt_pkg::CMD_W-1:0]    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status[1:0], has_region[2], region_addr[66:3], region_length[130:67],
	// region_device[162:131], region_handle[226:163], protocol_mask[230:227],
	// region_tag[262:231], zero pad
	output logic [mrrt_pkg::TDATA_W-1:0]  m_tdata,
	output logic                          m_tlast
);

	localparam int IW = $clog2(TABLE_ENTRIES);

	mrrt_pkg::ctl_t                    ctl;
	mrrt_pkg::sts_t                    sts;
	logic [IW-1:0]                     idx;
	logic [1:0]                        status;
	logic                              has_region;
	logic [mrrt_pkg::ADDR_W-1:0]       region_addr, region_length, region_handle;
	logic signed [mrrt_pkg::DEV_W-1:0] region_device;
	logic [mrrt_pkg::MASK_W-1:0]       protocol_mask;
	logic [mrrt_pkg::TAG_W-1:0]        region_tag;

	// sequencer: idle, scan every entry, decide, fetch the tag, hold the result
	mrrt_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.sts      (sts),
		.ctl      (ctl),
		.idx      (idx)
	);

	// unpack the input transfer straight into the datapath's command latch
	mrrt_dpath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.PROTOCOL_COUNT(PROTOCOL_COUNT)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.idx          (idx),
		.sts          (sts),
		.in_cmd       (s_tuser),
		.in_protocol  (s_tdata[1:0]),
		.in_device    (s_tdata[33:2]),
		.in_addr      (s_tdata[97:34]),
		.in_length    (s_tdata[161:98]),
		.in_handle    (s_tdata[225:162]),
		.in_tag       (s_tdata[257:226]),
		.status       (status),
		.has_region   (has_region),
		.region_addr  (region_addr),
		.region_length(region_length),
		.region_device(region_device),
		.region_handle(region_handle),
		.protocol_mask(protocol_mask),
		.region_tag   (region_tag),
		.last         (m_tlast)
	);

	// pack the held result; the top pad bit stays zero
	assign m_tdata = {1'b0, region_tag, protocol_mask, region_handle, region_device,
	                  region_length, region_addr, has_region, status};

	// never take a command while a result is pending
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("input ready while a result is held");

	// one command in flight: ready drops right after a transfer in
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second command accepted while busy");

	// after the final result goes out the block is idle again
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready)
		else $error("not idle after final result");

	// a result without an entry always ends its command
	a_plain_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2] |-> m_tlast)
		else $error("plain result not marked last");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench of the memory region range table.
// Depends on mrrt_pkg and memory_region_range_table; drives commands, predicts and checks results.
`timescale 1ns / 1ps

module testbench;

	localparam int ENTRIES = 16;
	localparam int PROTS   = 4;
	localparam longint unsigned CYCLE_LIMIT = 400000;

	// One result as the block shows it.
	typedef struct packed {
		mrrt_pkg::status_t status;
		logic              has_region;
		logic [63:0]       addr;
		logic [63:0]       length;
		logic [31:0]       device;
		logic [63:0]       handle;
		logic [3:0]        mask;
		logic [31:0]       tag;
		logic              last;
	} region_result_t;

	// Region table shadow and expected result queue.
	class region_scoreboard;
		bit          valid [ENTRIES];
		logic [63:0] start_a [ENTRIES];
		logic [63:0] len_a [ENTRIES];
		logic [31:0] dev_a [ENTRIES];
		logic [63:0] hnd_a [ENTRIES];
		logic [3:0]  prot_a [ENTRIES];
		logic [31:0] tag_a [ENTRIES][PROTS];
		region_result_t pending [$];
		int errors;
		int results_seen;

		function void add_expected(region_result_t r);
			pending = {pending, r};
		endfunction

		function void push_plain(mrrt_pkg::status_t st);
			region_result_t r;
			r = '0;
			r.status = st;
			r.last = 1'b1;
			add_expected(r);
		endfunction

		function region_result_t entry_result(int e, int p, bit lst);
			region_result_t r;
			r = '0;
			r.status = mrrt_pkg::ST_OK;
			r.has_region = 1'b1;
			r.addr = start_a[e];
			r.length = len_a[e];
			r.device = dev_a[e];
			r.handle = hnd_a[e];
			r.mask = prot_a[e];
			r.tag = tag_a[e][p];
			r.last = lst;
			return r;
		endfunction

		function bit registered(int e, int p);
			return valid[e] && prot_a[e][p];
		endfunction

		function mrrt_pkg::status_t check_range(logic [31:0] dev, logic [63:0] a,
				logic [63:0] len);
			int below, above;
			logic [64:0] endv, eend;
			below = -1;
			above = -1;
			if (a == 0 || len == 0) return mrrt_pkg::ST_INVALID;
			endv = {1'b0, a} + {1'b0, len};
			if (endv[64]) return mrrt_pkg::ST_INVALID;
			for (int e = 0; e < ENTRIES; e++) begin
				if (!valid[e] || dev_a[e] != dev) continue;
				if (start_a[e] == a)
					return (len_a[e] == len) ? mrrt_pkg::ST_OK : mrrt_pkg::ST_INVALID;
				if (start_a[e] > a) begin
					if (above < 0 || start_a[e] < start_a[above]) above = e;
				end else begin
					if (below < 0 || start_a[e] > start_a[below]) below = e;
				end
			end
			if (above >= 0 && {1'b0, start_a[above]} < endv) return mrrt_pkg::ST_INVALID;
			if (below >= 0) begin
				eend = {1'b0, start_a[below]} + {1'b0, len_a[below]};
				if (eend[64] || eend[63:0] > a) return mrrt_pkg::ST_INVALID;
			end
			return mrrt_pkg::ST_OK;
		endfunction

		function mrrt_pkg::status_t register_region(int p, logic [31:0] dev, logic [63:0] a,
				logic [63:0] len, logic [63:0] h, logic [31:0] tg);
			int slot;
			slot = -1;
			for (int e = 0; e < ENTRIES; e++)
				if (valid[e] && dev_a[e] == dev && start_a[e] == a) begin
					prot_a[e][p] = 1'b1;
					tag_a[e][p] = tg;
					return mrrt_pkg::ST_OK;
				end
			for (int e = 0; e < ENTRIES; e++) begin
				if (valid[e] && hnd_a[e] == h) return mrrt_pkg::ST_INVALID;
				if (!valid[e] && slot < 0) slot = e;
			end
			if (slot < 0) return mrrt_pkg::ST_FULL;
			valid[slot] = 1'b1;
			start_a[slot] = a;
			len_a[slot] = len;
			dev_a[slot] = dev;
			hnd_a[slot] = h;
			prot_a[slot] = 4'b0;
			prot_a[slot][p] = 1'b1;
			for (int q = 0; q < PROTS; q++) tag_a[slot][q] = '0;
			tag_a[slot][p] = tg;
			return mrrt_pkg::ST_OK;
		endfunction

		// Note one accepted command and queue what it must produce.
		function void note_command(mrrt_pkg::cmd_t c, int p, logic [31:0] dev,
				logic [63:0] a, logic [63:0] len, logic [63:0] h, logic [31:0] tg);
			int found, n, best;
			bit taken [ENTRIES];
			logic [63:0] off;
			found = -1;
			if (c == mrrt_pkg::CMD_VALIDATE) begin
				push_plain(check_range(dev, a, len));
				return;
			end
			if (c > mrrt_pkg::CMD_LIST || p >= PROTS) begin
				push_plain(mrrt_pkg::ST_INVALID);
				return;
			end
			case (c)
				mrrt_pkg::CMD_ADD: push_plain(register_region(p, dev, a, len, h, tg));
				mrrt_pkg::CMD_REMOVE: begin
					for (int e = 0; e < ENTRIES; e++)
						if (valid[e] && hnd_a[e] == h) found = e;
					if (found < 0) push_plain(mrrt_pkg::ST_INVALID);
					else begin
						prot_a[found][p] = 1'b0;
						if (prot_a[found] == 0) valid[found] = 1'b0;
						push_plain(mrrt_pkg::ST_OK);
					end
				end
				mrrt_pkg::CMD_LIST: begin
					n = 0;
					foreach (taken[e]) taken[e] = 0;
					while (n < mrrt_pkg::MAX_RESULTS) begin
						best = -1;
						for (int e = 0; e < ENTRIES; e++)
							if (registered(e, p) && !taken[e] &&
									(best < 0 || hnd_a[e] < hnd_a[best])) best = e;
						if (best < 0) break;
						taken[best] = 1;
						add_expected(entry_result(best, p, 1'b0));
						n++;
					end
					if (n == 0) push_plain(mrrt_pkg::ST_OK);
					else pending[$].last = 1'b1;
				end
				default: begin
					for (int e = 0; e < ENTRIES; e++) begin
						if (!registered(e, p)) continue;
						if (c == mrrt_pkg::CMD_FIND_HANDLE) begin
							if (hnd_a[e] == h) found = e;
						end else if (c == mrrt_pkg::CMD_FIND_START) begin
							if (dev_a[e] == dev && start_a[e] == a) found = e;
						end else begin
							if (dev_a[e] != dev || start_a[e] > a) continue;
							off = a - start_a[e];
							if (off <= len_a[e] && len <= len_a[e] - off &&
									(found < 0 || start_a[e] > start_a[found])) found = e;
						end
					end
					if (found < 0) push_plain(mrrt_pkg::ST_NOT_FOUND);
					else add_expected(entry_result(found, p, 1'b1));
				end
			endcase
		endfunction

		// Compare one transfer out against the oldest expectation.
		function void check_result(region_result_t got);
			region_result_t want;
			results_seen++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				$display("%0t: mismatch expected %h actual %h", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [mrrt_pkg::TDATA_W-1:0] s_tdata = '0;
	logic [mrrt_pkg::CMD_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [mrrt_pkg::TDATA_W-1:0] m_tdata;
	logic m_tlast;

	region_scoreboard table_sb;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	longint unsigned cycle_count = 0;
	int commands_sent = 0;

	memory_region_range_table DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Receiver: stall at random, check every transfer out.
	always @(posedge clk) begin
		region_result_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.status = mrrt_pkg::status_t'(m_tdata[1:0]);
				got.has_region = m_tdata[2];
				got.addr = m_tdata[66:3];
				got.length = m_tdata[130:67];
				got.device = m_tdata[162:131];
				got.handle = m_tdata[226:163];
				got.mask = m_tdata[230:227];
				got.tag = m_tdata[262:231];
				got.last = m_tlast;
				table_sb.check_result(got);
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Present one command and hold it until the transfer; idle first at random.
	task automatic send_command(mrrt_pkg::cmd_t c, logic [1:0] p, logic [31:0] dev,
			logic [63:0] a, logic [63:0] len, logic [63:0] h, logic [31:0] tg);
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= c;
		s_tdata <= {6'b0, tg, h, len, a, dev, p};
		do @(posedge clk); while (!s_tready);
		table_sb.note_command(c, p, dev, a, len, h, tg);
		commands_sent++;
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Mostly small addresses on few devices so ranges collide and lookups hit.
	task automatic send_random();
		mrrt_pkg::cmd_t c;
		logic [31:0] dev;
		logic [63:0] a, len, h;
		logic [1:0] p;
		int pick;
		pick = $urandom_range(99);
		c = (pick < 30) ? mrrt_pkg::CMD_ADD : mrrt_pkg::cmd_t'($urandom_range(7));
		p = 2'((pick % 10 == 0) ? $urandom : $urandom_range(PROTS - 1));
		dev = ($urandom_range(9) == 0) ? $urandom : $urandom_range(2);
		a = ($urandom_range(9) == 0) ? rand64() : 64'($urandom_range(15)) << 8;
		len = ($urandom_range(9) == 0) ? rand64() : 64'($urandom_range(4, 1024));
		h = ($urandom_range(9) == 0) ? rand64() : 64'($urandom_range(20));
		send_command(c, p, dev, a, len, h, $urandom);
	endtask

	initial begin
		logic [63:0] ones;
		ones = '1;
		table_sb = new();
		m_tready <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, extremes, wrap, exact duplicates, every command.
		send_command(mrrt_pkg::CMD_LIST, 2'd0, 32'd0, 64'd0, 64'd0, 64'd0, 32'd0);
		send_command(mrrt_pkg::CMD_VALIDATE, 2'd0, 32'd0, 64'd0, 64'd16, 64'd0, 32'd0);
		send_command(mrrt_pkg::CMD_VALIDATE, 2'd0, 32'd0, 64'd16, 64'd0, 64'd0, 32'd0);
		send_command(mrrt_pkg::CMD_VALIDATE, 2'd3, 32'h8000_0000, ones, 64'd2, ones,
			ones[31:0]);
		send_command(mrrt_pkg::CMD_ADD, 2'd0, 32'd1, 64'h1000, 64'h100, 64'd5, 32'hdead_beef);
		send_command(mrrt_pkg::CMD_ADD, 2'd1, 32'd1, 64'h1000, 64'h999, 64'd9, 32'h1234_5678);
		send_command(mrrt_pkg::CMD_ADD, 2'd0, 32'd1, 64'h2000, 64'h10, 64'd5, 32'd1);
		send_command(mrrt_pkg::CMD_ADD, 2'd3, 32'hffff_ffff, ones - 64'd15, 64'd16, ones,
			ones[31:0]);
		send_command(mrrt_pkg::CMD_ADD, 2'd2, 32'h7fff_ffff, 64'h8000_0000_0000_0000, ones,
			64'd0, 32'd7);
		send_command(mrrt_pkg::CMD_VALIDATE, 2'd0, 32'd1, 64'h1000, 64'h100, 64'd0, 32'd0);
		send_command(mrrt_pkg::CMD_VALIDATE, 2'd0, 32'd1, 64'h1000, 64'h80, 64'd0, 32'd0);
		send_command(mrrt_pkg::CMD_VALIDATE, 2'd0, 32'd1, 64'h1080, 64'h10, 64'd0, 32'd0);
		send_command(mrrt_pkg::CMD_VALIDATE, 2'd0, 32'd1, 64'h0f00, 64'h101, 64'd0, 32'd0);
		send_command(mrrt_pkg::CMD_VALIDATE, 2'd0, 32'h7fff_ffff, ones - 64'd1, 64'd1,
			64'd0, 32'd0);
		send_command(mrrt_pkg::CMD_FIND_HANDLE, 2'd1, 32'd0, 64'd0, 64'd0, 64'd5, 32'd0);
		send_command(mrrt_pkg::CMD_FIND_START, 2'd3, 32'hffff_ffff, ones - 64'd15, 64'd0,
			64'd0, 32'd0);
		send_command(mrrt_pkg::CMD_FIND_CONTAIN, 2'd0, 32'd1, 64'h1080, 64'h80, 64'd0, 32'd0);
		send_command(mrrt_pkg::CMD_FIND_CONTAIN, 2'd0, 32'd1, 64'h1080, 64'h81, 64'd0, 32'd0);
		send_command(mrrt_pkg::CMD_FIND_CONTAIN, 2'd2, 32'd1, 64'h1080, 64'h1, 64'd0, 32'd0);
		send_command(mrrt_pkg::CMD_LIST, 2'd0, 32'd0, 64'd0, 64'd0, 64'd0, 32'd0);
		send_command(mrrt_pkg::cmd_t'(3'd7), 2'd0, 32'd0, 64'd0, 64'd0, 64'd0, 32'd0);
		send_command(mrrt_pkg::CMD_REMOVE, 2'd0, 32'd0, 64'd0, 64'd0, 64'd5, 32'd0);
		send_command(mrrt_pkg::CMD_REMOVE, 2'd1, 32'd0, 64'd0, 64'd0, 64'd5, 32'd0);
		send_command(mrrt_pkg::CMD_REMOVE, 2'd1, 32'd0, 64'd0, 64'd0, 64'd5, 32'd0);
		// Fill the table past capacity to reach the full status.
		for (int i = 0; i < 17; i++)
			send_command(mrrt_pkg::CMD_ADD, 2'(i), 32'd3, 64'(i + 1) << 12, 64'h100,
				64'(100 + i), 32'(i));
		send_command(mrrt_pkg::CMD_LIST, 2'd1, 32'd0, 64'd0, 64'd0, 64'd0, 32'd0);
		// Drop each fill entry through the one protocol it was added with.
		for (int i = 0; i < 17; i++)
			send_command(mrrt_pkg::CMD_REMOVE, 2'(i), 32'd0, 64'd0, 64'd0, 64'(100 + i),
				32'd0);

		// Random phases: free flow, slow sender, slow receiver, both.
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1) ? 76 : (ph == 3) ? 38 : 0;
			recv_stall_pct = (ph == 2) ? 76 : (ph == 3) ? 38 : 0;
			for (int i = 0; i < 15; i++) send_random();
		end

		while (table_sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("Covered %0d commands and %0d results over four idle/stall phases.",
			commands_sent, table_sb.results_seen);
		if (table_sb.errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/mrrt_pkg.sv
hdl/mrrt_ctrl.sv
hdl/mrrt_dpath.sv
hdl/memory_region_range_table.sv
test/testbench.sv
